// ===== src/gtlb_pkg.sv =====
package gtlb_pkg;

    // Build constants
    localparam int PIXEL_SCALE = 2;
    localparam int MAX_TEXT    = 1024;

    // Field widths
    localparam int OFF_W      = 11;
    localparam int SUM_W      = 12;
    localparam int GLYPH_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int MAXW_W     = 10;
    localparam int CODE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Glyph width table
    localparam int TBL_DEPTH = 128;
    localparam int TBL_AW    = 7;

    // Result queue
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // Offsets saturate at the lesser of the text size and the field range
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'((MAX_TEXT < 2047) ? MAX_TEXT : 2047);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_SHIFT  = 8'h20;

    // Input actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEXT = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_WIDTH  = 2'd0,
        REG_FIRST_CODE = 2'd1,
        REG_LAST_CODE  = 2'd2
    } cfg_reg_e;

    localparam logic [MAXW_W-1:0] MAX_WIDTH_RST  = 10'd144;
    localparam logic [CODE_W-1:0] FIRST_CODE_RST = 7'd32;
    localparam logic [CODE_W-1:0] LAST_CODE_RST  = 7'd126;

    typedef struct packed {
        logic [MAXW_W-1:0] max_width;
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] last_code;
    } cfg_t;

    typedef struct packed {
        logic [OFF_W-1:0] line_start;
        logic [OFF_W-1:0] line_length;
        logic [OFF_W-1:0] next_start;
        logic             final_line;
        logic             run_end;
    } result_t;

    // Results of one character, written into the queue together
    typedef struct packed {
        logic                   valid;
        logic [RES_CNT_W-1:0]   count;
        result_t [MAX_RES-1:0]  res;
    } push_t;

endpackage

// ===== src/gtlb_char_if.sv =====
interface gtlb_char_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [gtlb_pkg::CHAR_W-1:0]    char_code;
    logic [gtlb_pkg::GLYPH_W-1:0]   glyph_width;
    logic                           last_char;

    modport source (output valid, output action, output char_code, output glyph_width,
                    output last_char, input ready);
    modport sink   (input valid, input action, input char_code, input glyph_width,
                    input last_char, output ready);
endinterface

// ===== src/gtlb_line_if.sv =====
interface gtlb_line_if;
    logic                         valid;
    logic                         ready;
    logic [gtlb_pkg::OFF_W-1:0]   line_start;
    logic [gtlb_pkg::OFF_W-1:0]   line_length;
    logic [gtlb_pkg::OFF_W-1:0]   next_start;
    logic                         final_line;
    logic                         run_end;

    modport source (output valid, output line_start, output line_length, output next_start,
                    output final_line, output run_end, input ready);
    modport sink   (input valid, input line_start, input line_length, input next_start,
                    input final_line, input run_end, output ready);
endinterface

// ===== src/gtlb_width_ram.sv =====
module gtlb_width_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [gtlb_pkg::TBL_AW-1:0]   waddr,
    input  logic [gtlb_pkg::GLYPH_W-1:0]  wdata,
    input  logic                          re,
    input  logic [gtlb_pkg::TBL_AW-1:0]   raddr,
    output logic [gtlb_pkg::GLYPH_W-1:0]  rdata
);

    logic [gtlb_pkg::GLYPH_W-1:0] mem [gtlb_pkg::TBL_DEPTH];
    logic [gtlb_pkg::GLYPH_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gtlb_wrap_core.sv =====
module gtlb_wrap_core (
    input  logic               clk,
    input  logic               rst_n,
    gtlb_char_if.sink          chars,
    input  gtlb_pkg::cfg_t     cfg,
    input  logic               room,
    output gtlb_pkg::push_t    push
);

    localparam int OFF_W = gtlb_pkg::OFF_W;
    localparam int SUM_W = gtlb_pkg::SUM_W;

    function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] v);
        return (v >= gtlb_pkg::OFF_LIMIT) ? gtlb_pkg::OFF_LIMIT : v + OFF_W'(1);
    endfunction

    function automatic logic [OFF_W-1:0] off_dist(input logic [OFF_W-1:0] hi,
                                                  input logic [OFF_W-1:0] lo);
        return (hi >= lo) ? hi - lo : '0;
    endfunction

    function automatic logic [SUM_W-1:0] sum_dist(input logic [SUM_W-1:0] hi,
                                                  input logic [SUM_W-1:0] lo);
        return (hi >= lo) ? hi - lo : '0;
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? gtlb_pkg::SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic gtlb_pkg::result_t make_line(input logic [OFF_W-1:0] start,
                                                    input logic [OFF_W-1:0] len,
                                                    input logic [OFF_W-1:0] next,
                                                    input logic fin);
        gtlb_pkg::result_t r;
        r.line_start  = start;
        r.line_length = len;
        r.next_start  = next;
        r.final_line  = fin;
        r.run_end     = 1'b0;
        return r;
    endfunction

    // Stage 0: accept, table write for loads, table read for text
    logic                           accept;
    logic                           in_ready;
    logic                           s1_fire;
    logic                           tbl_we;
    logic                           tbl_re;
    logic [gtlb_pkg::CHAR_W-1:0]    folded;
    logic [gtlb_pkg::CHAR_W-1:0]    mapped;
    logic [gtlb_pkg::CHAR_W-1:0]    rel_code;
    logic [gtlb_pkg::TBL_AW-1:0]    tbl_raddr;
    logic [gtlb_pkg::GLYPH_W-1:0]   tbl_rdata;

    logic                           s1_valid_reg;
    logic [gtlb_pkg::CHAR_W-1:0]    s1_code_reg;
    logic                           s1_last_reg;

    assign s1_fire     = s1_valid_reg && room;
    assign in_ready    = !s1_valid_reg || room;
    assign chars.ready = in_ready;
    assign accept      = chars.valid && in_ready;
    assign tbl_we      = accept && (chars.action == gtlb_pkg::ACT_LOAD);
    assign tbl_re      = accept && (chars.action == gtlb_pkg::ACT_TEXT);

    // Case fold, out-of-range codes map to the question mark entry
    always_comb
    begin
        if (chars.char_code >= gtlb_pkg::CH_LOWER_A && chars.char_code <= gtlb_pkg::CH_LOWER_Z)
        begin
            folded = chars.char_code - gtlb_pkg::CASE_SHIFT;
        end
        else
        begin
            folded = chars.char_code;
        end
        if (folded < {1'b0, cfg.first_code} || folded > {1'b0, cfg.last_code})
        begin
            mapped = gtlb_pkg::CH_QUESTION;
        end
        else
        begin
            mapped = folded;
        end
        rel_code  = mapped - {1'b0, cfg.first_code};
        tbl_raddr = rel_code[gtlb_pkg::TBL_AW-1:0];
    end

    gtlb_width_ram u_width_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (chars.char_code[gtlb_pkg::TBL_AW-1:0]),
        .wdata (chars.glyph_width),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= tbl_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_re)
        begin
            s1_code_reg <= chars.char_code;
            s1_last_reg <= chars.last_char;
        end
    end

    // Stage 1: line state
    logic [OFF_W-1:0] line_begin_reg, line_begin_next;
    logic [OFF_W-1:0] char_index_reg, char_index_next;
    logic [SUM_W-1:0] line_sum_reg, line_sum_next;
    logic [OFF_W-1:0] space_offset_reg, space_offset_next;
    logic             space_valid_reg, space_valid_next;
    logic [SUM_W-1:0] sts_reg, sts_next;

    logic [OFF_W-1:0] idx;
    logic [OFF_W-1:0] idx2;
    logic [OFF_W-1:0] after;
    logic [SUM_W-1:0] adv;
    logic [SUM_W-1:0] limit;
    logic [SUM_W-1:0] nw;
    logic [SUM_W-1:0] nw2;
    logic [SUM_W-1:0] rest_sum;
    logic             is_space;
    logic             at_current;
    logic             brk;
    logic             brk2;
    logic             ended;
    logic [gtlb_pkg::RES_CNT_W-1:0] n;
    gtlb_pkg::result_t              fin_line;
    gtlb_pkg::result_t [gtlb_pkg::MAX_RES-1:0] res;

    always_comb
    begin
        char_index_next   = off_inc(char_index_reg);
        line_begin_next   = line_begin_reg;
        line_sum_next     = line_sum_reg;
        space_offset_next = space_offset_reg;
        space_valid_next  = space_valid_reg;
        sts_next          = sts_reg;
        n                 = '0;
        ended             = 1'b0;
        res               = '0;
        fin_line          = '0;

        limit    = SUM_W'(cfg.max_width) + SUM_W'(gtlb_pkg::PIXEL_SCALE);
        adv      = SUM_W'(({1'b0, tbl_rdata} + 5'd1) * gtlb_pkg::PIXEL_SCALE);
        idx      = off_dist(char_index_reg, line_begin_reg);
        is_space = (s1_code_reg == gtlb_pkg::CH_SPACE) && (idx != '0);
        nw       = sum_add(line_sum_reg, adv);
        brk      = (idx != '0) && (nw > limit);

        // Space seen by this character counts for the break
        space_offset_next = is_space ? char_index_reg : space_offset_reg;
        space_valid_next  = space_valid_reg || is_space;
        after      = off_inc(space_offset_next);
        at_current = (space_offset_next == char_index_reg);

        // Rescan of the carried-over words after a space break
        rest_sum = sum_dist(line_sum_reg, sts_reg);
        idx2     = off_dist(char_index_reg, after);
        nw2      = sum_add(rest_sum, adv);
        brk2     = (idx2 != '0) && (nw2 > limit);

        if (s1_code_reg == gtlb_pkg::CH_NEWLINE)
        begin
            res[0] = make_line(line_begin_reg, idx, char_index_next, s1_last_reg);
            n                 = 2'd1;
            ended             = 1'b1;
            line_begin_next   = char_index_next;
            line_sum_next     = '0;
            space_offset_next = space_offset_reg;
            space_valid_next  = 1'b0;
            sts_next          = '0;
        end
        else
        begin
            if (brk)
            begin
                if (space_valid_next)
                begin
                    res[0] = make_line(line_begin_reg,
                                       off_dist(space_offset_next, line_begin_reg), after,
                                       at_current && s1_last_reg);
                    n                = 2'd1;
                    line_begin_next  = after;
                    space_valid_next = 1'b0;
                    if (at_current)
                    begin
                        line_sum_next = '0;
                        ended         = s1_last_reg;
                    end
                    else if (brk2)
                    begin
                        res[1] = make_line(after, idx2, char_index_reg, 1'b0);
                        n               = 2'd2;
                        line_begin_next = char_index_reg;
                        line_sum_next   = adv;
                    end
                    else
                    begin
                        line_sum_next = nw2;
                    end
                end
                else
                begin
                    res[0] = make_line(line_begin_reg, idx, char_index_reg, 1'b0);
                    n               = 2'd1;
                    line_begin_next = char_index_reg;
                    line_sum_next   = adv;
                end
            end
            else
            begin
                line_sum_next = nw;
                if (is_space)
                begin
                    sts_next = nw;
                end
            end

            // Open line closes at the end of the text
            if (s1_last_reg && !ended)
            begin
                fin_line = make_line(line_begin_next,
                                     off_dist(char_index_next, line_begin_next),
                                     char_index_next, 1'b1);
                case (n)
                    2'd0:    res[0] = fin_line;
                    2'd1:    res[1] = fin_line;
                    default: res[2] = fin_line;
                endcase
                n = n + 2'd1;
            end
        end

        // Mark the last line of this character
        case (n)
            2'd1:    res[0].run_end = 1'b1;
            2'd2:    res[1].run_end = 1'b1;
            2'd3:    res[2].run_end = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_begin_reg   <= '0;
            char_index_reg   <= '0;
            line_sum_reg     <= '0;
            space_offset_reg <= '0;
            space_valid_reg  <= 1'b0;
            sts_reg          <= '0;
        end
        else if (s1_fire)
        begin
            line_begin_reg   <= line_begin_next;
            char_index_reg   <= char_index_next;
            line_sum_reg     <= line_sum_next;
            space_offset_reg <= space_offset_next;
            space_valid_reg  <= space_valid_next;
            sts_reg          <= sts_next;
        end
    end

    assign push.valid = s1_fire;
    assign push.count = n;
    assign push.res   = res;

endmodule

// ===== src/gtlb_out_fifo.sv =====
module gtlb_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  gtlb_pkg::push_t   push,
    output logic              room,
    gtlb_line_if.source       lines
);

    localparam int AW = gtlb_pkg::FIFO_AW;

    gtlb_pkg::result_t store [gtlb_pkg::FIFO_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW:0]   push_cnt;
    logic          pop;
    gtlb_pkg::result_t head;

    assign pop      = lines.valid && lines.ready;
    assign push_cnt = push.valid ? (AW+1)'(push.count) : '0;
    assign room     = count_reg <= (AW+1)'(gtlb_pkg::FIFO_DEPTH - gtlb_pkg::MAX_RES);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt[AW-1:0];
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + push_cnt - (AW+1)'(pop);
    end

    // Up to three results land in one cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < gtlb_pkg::MAX_RES; i++)
        begin
            if (push.valid && (gtlb_pkg::RES_CNT_W'(i) < push.count))
            begin
                store[wr_ptr_reg + AW'(i)] <= push.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head              = store[rd_ptr_reg];
    assign lines.valid       = count_reg != '0;
    assign lines.line_start  = head.line_start;
    assign lines.line_length = head.line_length;
    assign lines.next_start  = head.next_start;
    assign lines.final_line  = head.final_line;
    assign lines.run_end     = head.run_end;

endmodule

// ===== src/greedy_text_line_breaker.sv =====
// Channel   Role    Handshake         Payload
// chars     sink    valid/ready       action, char_code, glyph_width, last_char
// lines     source  valid/ready       line_start, line_length, next_start, final_line, run_end
// config    write   wr_en (no wait)   wr_index, wr_data
//
// One item per cycle while no stall holds the line stage: a load writes the glyph table at
// its accept edge; a character reads the table at accept and updates the line state from
// the registered data. Its results enter an 8-deep queue then and show on lines from the
// next cycle, one a cycle while lines.ready is high. A character waiting in the line stage
// stalls there, and holds chars.ready low, while the queue has fewer than 3 free slots.
// Reset clears line state, offsets and queue; the glyph table holds no reset value.
module greedy_text_line_breaker (
    input  logic                              clk,
    input  logic                              rst_n,
    gtlb_char_if.sink                         chars,
    gtlb_line_if.source                       lines,
    input  logic                              wr_en,
    input  logic [gtlb_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [gtlb_pkg::CFG_DATA_W-1:0]   wr_data
);

    gtlb_pkg::cfg_t  cfg_reg;
    gtlb_pkg::push_t push;
    logic            room;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_width  <= gtlb_pkg::MAX_WIDTH_RST;
            cfg_reg.first_code <= gtlb_pkg::FIRST_CODE_RST;
            cfg_reg.last_code  <= gtlb_pkg::LAST_CODE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                gtlb_pkg::REG_MAX_WIDTH:  cfg_reg.max_width  <= wr_data[gtlb_pkg::MAXW_W-1:0];
                gtlb_pkg::REG_FIRST_CODE: cfg_reg.first_code <= wr_data[gtlb_pkg::CODE_W-1:0];
                gtlb_pkg::REG_LAST_CODE:  cfg_reg.last_code  <= wr_data[gtlb_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    gtlb_wrap_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .cfg   (cfg_reg),
        .room  (room),
        .push  (push)
    );

    gtlb_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .lines (lines)
    );

`ifndef ASSERT_OFF
    // Line stage only advances with room for a full set of results
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> room)
        else $error("results pushed without queue room");

    // run_end sits on the last result of a character only
    a_run_end_two: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.count == 2'd2) |-> (push.res[1].run_end && !push.res[0].run_end))
        else $error("run_end misplaced in two-line transaction");

    a_run_end_three: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.count == 2'd3) |->
            (push.res[2].run_end && !push.res[1].run_end && !push.res[0].run_end))
        else $error("run_end misplaced in three-line transaction");

    // The final line of a text is always the last result of its character
    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (lines.valid && lines.final_line) |-> lines.run_end)
        else $error("final line not marked run_end");
`endif

endmodule
